// ===== rtl/cpfa_pkg.sv =====
// Shared constants and types for the contiguous page frame allocator.
package cpfa_pkg;

    localparam int MAX_FRAMES  = 1024;
    localparam int FRAME_SHIFT = 12;
    localparam int ADDR_W      = 52;
    localparam int COUNT_W     = 11;
    localparam int WORD_W      = 32;
    localparam int WORDS       = MAX_FRAMES / WORD_W;
    localparam int WIDX_W      = $clog2(WORDS);
    localparam int WBIT_W      = $clog2(WORD_W);
    localparam int FIDX_W      = $clog2(MAX_FRAMES) + 1;
    localparam int LEN_W       = FIDX_W + 1;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [FIDX_W-1:0]  fidx_t;
    typedef logic [WIDX_W-1:0]  widx_t;
    typedef logic [WBIT_W-1:0]  wbit_t;
    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [WORD_W-1:0]  word_t;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic CFG_REGION_BASE = 1'b0;
    localparam logic CFG_FRAME_COUNT = 1'b1;

endpackage

// ===== rtl/contiguous_page_frame_allocator.sv =====
// First-fit contiguous page frame allocator with a 1024-bit used map held as 32 words.
// Each accepted beat is decoded; an allocate then runs a first-fit scan of up to 32 words, and a
// successful allocate or a matching free of a nonzero count sweeps up to 32 words to set or clear
// its frames, one 32-frame word per cycle; the result then waits in the done state for the output.
// A new beat is taken only once the previous one is done and the block is idle, later while the
// previous result is stalled. Reset clears the used map, configuration and control state.
module contiguous_page_frame_allocator
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [cpfa_pkg::ADDR_W-1:0]   cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [cpfa_pkg::COUNT_W-1:0]  page_count,
    input  logic [cpfa_pkg::ADDR_W-1:0]   address,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cpfa_pkg::ADDR_W-1:0]   result_address,
    output logic                          ok
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_MARK,
        ST_DONE
    } state_t;

    localparam int WORD_W = cpfa_pkg::WORD_W;
    localparam int FIDX_W = cpfa_pkg::FIDX_W;
    localparam int LEN_W  = cpfa_pkg::LEN_W;

    // Configuration registers.
    cpfa_pkg::addr_t  region_base_reg;
    cpfa_pkg::count_t frame_count_reg;

    // The used map, one bit per frame, packed into words that the sequencer walks.
    cpfa_pkg::word_t  map_reg [cpfa_pkg::WORDS];

    // Sequencer state and the captured beat.
    state_t           state_reg;
    logic             cmd_reg;
    cpfa_pkg::count_t count_reg;
    cpfa_pkg::addr_t  addr_reg;
    cpfa_pkg::widx_t  w_reg;
    cpfa_pkg::fidx_t  carry_reg;
    cpfa_pkg::fidx_t  lo_reg;
    cpfa_pkg::fidx_t  hi_reg;
    logic             set_reg;
    logic             ok_reg;

    // Output register.
    logic             out_valid_reg;
    cpfa_pkg::addr_t  result_address_reg;
    logic             ok_out_reg;

    // Effective limit is the configured frame count clamped to the map size.
    cpfa_pkg::fidx_t  lim;

    // Free request decode: byte offset from the region base and the frame it names.
    cpfa_pkg::addr_t  offset;
    cpfa_pkg::fidx_t  free_idx;
    logic             free_match;
    logic [LEN_W-1:0] free_end;
    cpfa_pkg::fidx_t  free_hi;

    // Scan unit: works on one word of the map per cycle.
    cpfa_pkg::word_t  used_w;
    cpfa_pkg::word_t  found_w;
    cpfa_pkg::len_t   len_w [WORD_W];
    logic [cpfa_pkg::WBIT_W:0] last_w [WORD_W];
    cpfa_pkg::wbit_t  first_j;
    logic             any_found;
    cpfa_pkg::fidx_t  scan_start;
    cpfa_pkg::fidx_t  carry_next;
    logic             scan_last_word;

    // Sweep unit: sets or clears the bits of one word that fall in [lo, hi).
    cpfa_pkg::word_t  mask_w;
    cpfa_pkg::fidx_t  hi_minus_one;
    logic             mark_last_word;

    // Highest used bit at or below position j, with a flag that one exists.
    function automatic logic [cpfa_pkg::WBIT_W:0] last_used(cpfa_pkg::word_t u, int j);
        logic [cpfa_pkg::WBIT_W:0] r;
        r = '0;
        for (int k = 0; k < cpfa_pkg::WORD_W; k++)
        begin
            if (k <= j && u[k])
            begin
                r = {1'b1, cpfa_pkg::WBIT_W'(k)};
            end
        end
        return r;
    endfunction

    assign lim = (frame_count_reg > FIDX_W'(cpfa_pkg::MAX_FRAMES))
               ? FIDX_W'(cpfa_pkg::MAX_FRAMES) : frame_count_reg;

    // An address matches when the offset is frame aligned and its frame is below the limit.
    assign offset     = addr_reg - region_base_reg;
    assign free_idx   = offset[cpfa_pkg::FRAME_SHIFT +: FIDX_W];
    assign free_match = (offset[cpfa_pkg::FRAME_SHIFT-1:0] == '0)
                     && (offset[cpfa_pkg::ADDR_W-1:cpfa_pkg::FRAME_SHIFT+FIDX_W] == '0)
                     && (free_idx < lim);
    assign free_end   = LEN_W'(free_idx) + LEN_W'(count_reg);
    assign free_hi    = (free_end > LEN_W'(lim)) ? lim : free_end[FIDX_W-1:0];

    // Each bit of the current word is a frame; frames at or above the limit count as used.
    // The free run ending at bit j either reaches back into earlier words (carry) or
    // starts just past the last used bit in this word.
    always_comb
    begin
        for (int j = 0; j < WORD_W; j++)
        begin
            used_w[j] = map_reg[w_reg][j]
                     || (FIDX_W'({w_reg, cpfa_pkg::WBIT_W'(j)}) >= lim);
        end
        for (int j = 0; j < WORD_W; j++)
        begin
            last_w[j] = last_used(used_w, j);
            if (last_w[j][cpfa_pkg::WBIT_W])
            begin
                len_w[j] = LEN_W'(j) - LEN_W'(last_w[j][cpfa_pkg::WBIT_W-1:0]);
            end
            else
            begin
                len_w[j] = LEN_W'(carry_reg) + LEN_W'(j) + LEN_W'(1);
            end
            found_w[j] = !used_w[j] && (len_w[j] >= LEN_W'(count_reg));
        end
        first_j = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (found_w[j])
            begin
                first_j = cpfa_pkg::WBIT_W'(j);
            end
        end
    end

    assign any_found  = |found_w;
    assign scan_start = FIDX_W'({w_reg, first_j}) + FIDX_W'(1) - FIDX_W'(count_reg);
    assign carry_next = last_w[WORD_W-1][cpfa_pkg::WBIT_W]
                      ? FIDX_W'(WORD_W - 1) - FIDX_W'(last_w[WORD_W-1][cpfa_pkg::WBIT_W-1:0])
                      : carry_reg + FIDX_W'(WORD_W);
    // The scan ends once the next word would start at or beyond the limit.
    assign scan_last_word = (FIDX_W'({1'b0, w_reg} + 1) << cpfa_pkg::WBIT_W) >= lim;

    always_comb
    begin
        for (int j = 0; j < WORD_W; j++)
        begin
            mask_w[j] = (FIDX_W'({w_reg, cpfa_pkg::WBIT_W'(j)}) >= lo_reg)
                     && (FIDX_W'({w_reg, cpfa_pkg::WBIT_W'(j)}) < hi_reg);
        end
    end

    assign hi_minus_one   = hi_reg - FIDX_W'(1);
    assign mark_last_word = (w_reg == hi_minus_one[FIDX_W-2:cpfa_pkg::WBIT_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg <= '0;
            frame_count_reg <= '0;
            for (int i = 0; i < cpfa_pkg::WORDS; i++)
            begin
                map_reg[i] <= '0;
            end
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    cpfa_pkg::CFG_REGION_BASE: region_base_reg <= cfg_data;
                    cpfa_pkg::CFG_FRAME_COUNT: frame_count_reg <= cfg_data[cpfa_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end

            // The output register loads from the done state when it is free or being
            // emptied this cycle, and otherwise drains when the receiver takes the beat.
            if (state_reg == ST_DONE && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg   <= cmd;
                        count_reg <= page_count;
                        addr_reg  <= address;
                        state_reg <= ST_DECODE;
                    end
                end

                ST_DECODE:
                begin
                    carry_reg <= '0;
                    if (cmd_reg == cpfa_pkg::CMD_ALLOC)
                    begin
                        ok_reg <= 1'b0;
                        w_reg  <= '0;
                        if (count_reg == '0 || count_reg > lim)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                    else
                    begin
                        ok_reg  <= free_match;
                        lo_reg  <= free_idx;
                        hi_reg  <= free_hi;
                        set_reg <= 1'b0;
                        w_reg   <= free_idx[FIDX_W-2:cpfa_pkg::WBIT_W];
                        // A zero count frees nothing but still reports the match.
                        if (free_match && free_hi > free_idx)
                        begin
                            state_reg <= ST_MARK;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end

                ST_SCAN:
                begin
                    if (any_found)
                    begin
                        ok_reg    <= 1'b1;
                        lo_reg    <= scan_start;
                        hi_reg    <= scan_start + FIDX_W'(count_reg);
                        set_reg   <= 1'b1;
                        w_reg     <= scan_start[FIDX_W-2:cpfa_pkg::WBIT_W];
                        state_reg <= ST_MARK;
                    end
                    else if (scan_last_word)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        w_reg     <= w_reg + 1'b1;
                        carry_reg <= carry_next;
                    end
                end

                ST_MARK:
                begin
                    if (set_reg)
                    begin
                        map_reg[w_reg] <= map_reg[w_reg] | mask_w;
                    end
                    else
                    begin
                        map_reg[w_reg] <= map_reg[w_reg] & ~mask_w;
                    end
                    if (mark_last_word)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        w_reg <= w_reg + 1'b1;
                    end
                end

                ST_DONE:
                begin
                    // Wait until the output register is free or being emptied this cycle.
                    if (!out_valid_reg || !out_stall)
                    begin
                        ok_out_reg <= ok_reg;
                        if (ok_reg && cmd_reg == cpfa_pkg::CMD_ALLOC)
                        begin
                            result_address_reg <= region_base_reg
                                + cpfa_pkg::ADDR_W'({lo_reg, cpfa_pkg::FRAME_SHIFT'(0)});
                        end
                        else
                        begin
                            result_address_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign result_address = result_address_reg;
    assign ok             = ok_out_reg;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the first-fit contiguous page frame allocator.
module tb;

    // A run that is still going after this many cycles has hung. The slowest legal run is
    // about 2000 requests, each taking its scan and sweep in the block plus sender gaps and
    // receiver stalls, well under this limit.
    localparam int CYCLE_LIMIT = 2000000;

    // One request as the sender presents it.
    typedef struct packed
    {
        logic             cmd;
        cpfa_pkg::count_t cnt;
        cpfa_pkg::addr_t  addr;
    } req_t;

    // One reply as the block should return it.
    typedef struct packed
    {
        cpfa_pkg::addr_t addr;
        logic            ok;
    } grant_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;

    logic   cfg_write = 1'b0;
    logic   cfg_index = 1'b0;
    cpfa_pkg::addr_t  cfg_data = '0;

    logic   in_valid = 1'b0;
    logic   in_stall;
    logic   cmd = 1'b0;
    cpfa_pkg::count_t page_count = '0;
    cpfa_pkg::addr_t  address = '0;

    logic   out_valid;
    logic   out_stall = 1'b0;
    cpfa_pkg::addr_t  result_address;
    logic   ok;

    // Requests waiting for the driver, and replies the block still owes us.
    req_t   req_q[$];
    grant_t grant_q[$];

    // Our own view of the allocator: the two registers and the frame usage map.
    cpfa_pkg::addr_t  base_shadow = '0;
    cpfa_pkg::count_t count_shadow = '0;
    logic   frame_busy[cpfa_pkg::MAX_FRAMES];

    int     errors = 0;
    int     cycles = 0;
    logic   in_taken = 1'b0;
    int     gap_left = 0;
    int     burst_left = 0;

    contiguous_page_frame_allocator dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .page_count     (page_count),
        .address        (address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_address (result_address),
        .ok             (ok)
    );

    always #1 clk = ~clk;

    // Works out the reply to one request and applies its effect to the usage map.
    // Allocation looks for the first free stretch of the requested length by keeping a
    // running count of consecutive free frames; the first frame where that count reaches
    // the request is the end of the lowest fitting run.
    function automatic grant_t grant_for(req_t r);
        grant_t g;
        int     lim;
        int     need;
        int     run;
        int     first;
        int     start;
        cpfa_pkg::addr_t offset;
        cpfa_pkg::addr_t slot;
        g.addr = '0;
        g.ok   = 1'b0;
        lim    = (count_shadow > cpfa_pkg::MAX_FRAMES) ? cpfa_pkg::MAX_FRAMES
                                                       : int'(count_shadow);
        need   = int'(r.cnt);
        if (r.cmd == cpfa_pkg::CMD_ALLOC)
        begin
            // A zero count or one larger than the managed area can never succeed.
            if (need != 0 && need <= lim)
            begin
                run   = 0;
                first = -1;
                for (int i = 0; i < lim && first < 0; i++)
                begin
                    run = frame_busy[i] ? 0 : run + 1;
                    if (run == need)
                        first = i - need + 1;
                end
                if (first >= 0)
                begin
                    for (int i = first; i < first + need; i++)
                        frame_busy[i] = 1'b1;
                    g.addr = base_shadow
                           + (cpfa_pkg::addr_t'(first) << cpfa_pkg::FRAME_SHIFT);
                    g.ok   = 1'b1;
                end
            end
        end
        else
        begin
            // The address matches only when it sits exactly on a managed frame, counted
            // from the base with wraparound at the top of the address space.
            offset = r.addr - base_shadow;
            slot   = offset >> cpfa_pkg::FRAME_SHIFT;
            if (offset[cpfa_pkg::FRAME_SHIFT-1:0] == '0 && slot < cpfa_pkg::addr_t'(lim))
            begin
                g.ok  = 1'b1;
                start = int'(slot);
                // The sweep stops at the last managed frame even if the count runs on.
                for (int i = start; i < lim && i < start + need; i++)
                    frame_busy[i] = 1'b0;
            end
        end
        return g;
    endfunction

    function automatic cpfa_pkg::addr_t rand_addr();
        return cpfa_pkg::addr_t'({$urandom, $urandom});
    endfunction

    // Mostly short runs, some medium ones, and now and then anything up to the limit.
    function automatic int pick_count(int lim);
        int k;
        k = $urandom_range(0, 99);
        if (k < 80)
            return $urandom_range(1, 8);
        if (k < 95)
            return $urandom_range(9, 64);
        return $urandom_range(1, (lim > 0) ? lim : 1);
    endfunction

    function automatic void queue_req(logic c, int n, cpfa_pkg::addr_t a);
        req_t r;
        r.cmd  = c;
        r.cnt  = cpfa_pkg::count_t'(n);
        r.addr = a;
        req_q.push_back(r);
    endfunction

    // Random traffic for one setting. Most requests are allocations and frees of real
    // frame addresses, so the map keeps fragmenting and refilling. The rest are
    // malformed: unaligned or out-of-range addresses, zero counts and raw noise.
    task automatic add_random(int n, cpfa_pkg::addr_t base, int lim);
        int kind;
        int slot;
        for (int j = 0; j < n; j++)
        begin
            kind = $urandom_range(0, 99);
            slot = (lim > 0) ? $urandom_range(0, lim - 1) : 0;
            if (kind < 55)
                queue_req(cpfa_pkg::CMD_ALLOC, pick_count(lim), rand_addr());
            else if (kind < 88 && lim > 0)
                queue_req(cpfa_pkg::CMD_FREE, pick_count(lim),
                          base + (cpfa_pkg::addr_t'(slot) << cpfa_pkg::FRAME_SHIFT));
            else
            begin
                case ($urandom_range(0, 3))
                    0: queue_req(1'($urandom_range(0, 1)), $urandom_range(0, 2047),
                                 rand_addr());
                    1: queue_req(cpfa_pkg::CMD_FREE, pick_count(lim),
                                 base + (cpfa_pkg::addr_t'(slot) << cpfa_pkg::FRAME_SHIFT)
                                 + cpfa_pkg::addr_t'($urandom_range(1, 4095)));
                    2: queue_req(cpfa_pkg::CMD_FREE, pick_count(lim),
                                 base + (cpfa_pkg::addr_t'(lim + $urandom_range(0, 63))
                                         << cpfa_pkg::FRAME_SHIFT));
                    default: queue_req(1'($urandom_range(0, 1)), 0,
                                       base + (cpfa_pkg::addr_t'(slot)
                                               << cpfa_pkg::FRAME_SHIFT));
                endcase
            end
        end
    endtask

    // Register writes happen only while the block is idle, so the shadow copy can be
    // updated right away.
    task automatic write_cfg(logic idx, cpfa_pkg::addr_t data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == cpfa_pkg::CFG_REGION_BASE)
            base_shadow = data;
        else
            count_shadow = data[cpfa_pkg::COUNT_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Waits until every request has gone in and every reply has come back, and then a
    // while longer so the block is surely back at rest.
    task automatic wait_idle();
        while (req_q.size() != 0 || in_valid || grant_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Sender: bursts of beats separated by random gaps. A beat stays on the bus until
    // the block takes it; only then does the driver move on.
    always @(negedge clk)
    begin
        logic  drive;
        req_t  r;
        int    style;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && !in_taken))
        begin
            drive = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (req_q.size() > 0)
            begin
                r = req_q.pop_front();
                cmd        <= r.cmd;
                page_count <= r.cnt;
                address    <= r.addr;
                drive = 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    // Pick the shape of the next burst: back to back, short gaps, a long
                    // pause, or a long stretch with no idling at all.
                    style = $urandom_range(0, 9);
                    if (style < 4)
                    begin
                        gap_left   = 0;
                        burst_left = $urandom_range(1, 30);
                    end
                    else if (style < 8)
                    begin
                        gap_left   = $urandom_range(1, 4);
                        burst_left = $urandom_range(1, 10);
                    end
                    else if (style == 8)
                    begin
                        gap_left   = $urandom_range(10, 60);
                        burst_left = $urandom_range(1, 5);
                    end
                    else
                    begin
                        gap_left   = 0;
                        burst_left = $urandom_range(40, 120);
                    end
                end
            end
            in_valid <= drive;
        end
    end

    // Receiver: stalls follow a pattern that switches between none, light and heavy.
    // Periodically it also holds off for a long stretch while the sender
    // keeps offering beats, so the block backs up and has to stall its input.
    always @(negedge clk)
    begin
        int stall_clock;
        int hold_left;
        int mode;
        int mode_left;
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_clock = 0;
            hold_left   = 0;
            mode        = 0;
            mode_left   = 0;
        end
        else
        begin
            stall_clock++;
            if (hold_left == 0 && stall_clock % 7000 == 500)
                hold_left = 400;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Monitor: checks each reply against the oldest prediction, then records the request
    // taken at this edge. A reply can never come on the edge its request goes in, so
    // checking first is safe.
    always @(posedge clk)
    begin
        grant_t g;
        req_t   r;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("tb failed");
                $finish;
            end
            else
            begin
                if (out_valid && !out_stall)
                begin
                    if (grant_q.size() == 0)
                    begin
                        if (errors < 10)
                            $display("unexpected reply: address %h ok %b",
                                     result_address, ok);
                        errors++;
                    end
                    else
                    begin
                        g = grant_q.pop_front();
                        if (result_address !== g.addr || ok !== g.ok)
                        begin
                            if (errors < 10)
                                $display("mismatch: expected address %h ok %b, got %h ok %b",
                                         g.addr, g.ok, result_address, ok);
                            errors++;
                        end
                    end
                end
                if (in_valid && !in_stall)
                begin
                    r.cmd  = cmd;
                    r.cnt  = page_count;
                    r.addr = address;
                    grant_q.push_back(grant_for(r));
                end
                in_taken <= in_valid && !in_stall;
            end
        end
    end

    initial
    begin
        cpfa_pkg::addr_t b;
        for (int i = 0; i < cpfa_pkg::MAX_FRAMES; i++)
            frame_busy[i] = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Straight out of reset nothing is managed, so every request must fail.
        queue_req(cpfa_pkg::CMD_ALLOC, 1, '0);
        queue_req(cpfa_pkg::CMD_FREE, 1, '0);
        queue_req(cpfa_pkg::CMD_ALLOC, 0, '0);
        wait_idle();

        // Full-size region at an aligned base, walked through the corner cases by hand.
        b = 52'h0_0000_8000_0000;
        write_cfg(cpfa_pkg::CFG_REGION_BASE, b);
        write_cfg(cpfa_pkg::CFG_FRAME_COUNT, cpfa_pkg::addr_t'(1024));
        // Zero count fails.
        queue_req(cpfa_pkg::CMD_ALLOC, 0, rand_addr());
        // Frame 0, then frames 1 to 3.
        queue_req(cpfa_pkg::CMD_ALLOC, 1, '0);
        queue_req(cpfa_pkg::CMD_ALLOC, 3, '1);
        // Exactly the limit fails while frames are in use; more than the limit and the
        // largest count fail too.
        queue_req(cpfa_pkg::CMD_ALLOC, 1024, '0);
        queue_req(cpfa_pkg::CMD_ALLOC, 1025, '0);
        queue_req(cpfa_pkg::CMD_ALLOC, 2047, '0);
        // Matches but frees nothing, frees frame 1, then frees it again.
        queue_req(cpfa_pkg::CMD_FREE, 0, b + (cpfa_pkg::addr_t'(1) << cpfa_pkg::FRAME_SHIFT));
        queue_req(cpfa_pkg::CMD_FREE, 1, b + (cpfa_pkg::addr_t'(1) << cpfa_pkg::FRAME_SHIFT));
        queue_req(cpfa_pkg::CMD_FREE, 1, b + (cpfa_pkg::addr_t'(1) << cpfa_pkg::FRAME_SHIFT));
        // Skips the one-frame hole, then fills it.
        queue_req(cpfa_pkg::CMD_ALLOC, 2, '0);
        queue_req(cpfa_pkg::CMD_ALLOC, 1, '0);
        // Unaligned, just below the base, and one past the last frame.
        queue_req(cpfa_pkg::CMD_FREE, 1, b + cpfa_pkg::addr_t'(1));
        queue_req(cpfa_pkg::CMD_FREE, 1, b - (cpfa_pkg::addr_t'(1) << cpfa_pkg::FRAME_SHIFT));
        queue_req(cpfa_pkg::CMD_FREE, 1,
                  b + (cpfa_pkg::addr_t'(1024) << cpfa_pkg::FRAME_SHIFT));
        // Runs past the limit, then clears everything.
        queue_req(cpfa_pkg::CMD_FREE, 2047,
                  b + (cpfa_pkg::addr_t'(1023) << cpfa_pkg::FRAME_SHIFT));
        queue_req(cpfa_pkg::CMD_FREE, 1024, b);
        // Whole region, then nothing left.
        queue_req(cpfa_pkg::CMD_ALLOC, 1024, '0);
        queue_req(cpfa_pkg::CMD_ALLOC, 1, '0);
        // All-ones address.
        queue_req(cpfa_pkg::CMD_FREE, 2047, '1);
        queue_req(cpfa_pkg::CMD_FREE, 2047, b);
        queue_req(cpfa_pkg::CMD_ALLOC, 1023, '0);
        // Last frame.
        queue_req(cpfa_pkg::CMD_ALLOC, 1, '0);
        queue_req(cpfa_pkg::CMD_FREE, 10, b + (cpfa_pkg::addr_t'(512) << cpfa_pkg::FRAME_SHIFT));
        // Hole too small, then hole exactly right.
        queue_req(cpfa_pkg::CMD_ALLOC, 11, '0);
        queue_req(cpfa_pkg::CMD_ALLOC, 10, '0);
        add_random(500, b, 1024);
        wait_idle();

        // Base near the top of the address space so frame addresses wrap, and the
        // largest count value, which the block clamps. Upper data bits carry garbage.
        b = 52'hF_FFFF_FFFF_8000;
        write_cfg(cpfa_pkg::CFG_REGION_BASE, b);
        write_cfg(cpfa_pkg::CFG_FRAME_COUNT,
                  {rand_addr()} << cpfa_pkg::COUNT_W | cpfa_pkg::addr_t'(11'h7FF));
        add_random(500, b, 1024);
        wait_idle();

        // Unaligned random base and a small region; frames above it keep their state.
        b = rand_addr();
        write_cfg(cpfa_pkg::CFG_REGION_BASE, b);
        write_cfg(cpfa_pkg::CFG_FRAME_COUNT, cpfa_pkg::addr_t'(40));
        add_random(400, b, 40);
        wait_idle();

        // A single managed frame at the very top address.
        b = '1;
        write_cfg(cpfa_pkg::CFG_REGION_BASE, b);
        write_cfg(cpfa_pkg::CFG_FRAME_COUNT, cpfa_pkg::addr_t'(1));
        add_random(100, b, 1);
        wait_idle();

        // Nothing managed at all.
        write_cfg(cpfa_pkg::CFG_FRAME_COUNT, '0);
        add_random(20, b, 0);
        wait_idle();

        // Back to the full region at address zero; the bits left from earlier reappear.
        b = '0;
        write_cfg(cpfa_pkg::CFG_REGION_BASE, b);
        write_cfg(cpfa_pkg::CFG_FRAME_COUNT, cpfa_pkg::addr_t'(1024));
        add_random(500, b, 1024);
        wait_idle();

        // Allow time for any stray reply to show up before the verdict.
        repeat (100) @(posedge clk);
        if (errors == 0 && grant_q.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cpfa_pkg.sv
rtl/contiguous_page_frame_allocator.sv
tb/tb.sv
